/* rtl/core/tsu_pkg.sv */
package tsu_pkg;

    // Token kind codes
    localparam logic [3:0] KIND_EOF      = 4'd0;
    localparam logic [3:0] KIND_NUM      = 4'd1;
    localparam logic [3:0] KIND_IDENT    = 4'd2;
    localparam logic [3:0] KIND_LPAREN   = 4'd3;
    localparam logic [3:0] KIND_RPAREN   = 4'd4;
    localparam logic [3:0] KIND_LBRACE   = 4'd5;
    localparam logic [3:0] KIND_RBRACE   = 4'd6;
    localparam logic [3:0] KIND_STAR     = 4'd7;
    localparam logic [3:0] KIND_STARSTAR = 4'd8;
    localparam logic [3:0] KIND_PLUS     = 4'd9;
    localparam logic [3:0] KIND_MINUS    = 4'd10;
    localparam logic [3:0] KIND_SLASH    = 4'd11;
    localparam logic [3:0] KIND_SEMI     = 4'd12;
    localparam logic [3:0] KIND_COMMA    = 4'd13;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd14;
    localparam logic [3:0] KIND_NULLDIAG = 4'd15;

    // Characters with a role in the scan
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Result queue
    localparam int QDEPTH   = 4;
    localparam int MAX_RES  = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } result_t;

endpackage

/* rtl/core/token_scanner_unit.sv */
// Results: the beats that a byte causes are registered into the result queue when that byte is accepted.
// Throughput: one byte per cycle while at most one result beat waits in the queue;
// a byte that closes a token and emits two or three beats holds in_ready low until
// the four-entry result queue has drained enough to take another three beats.
// Reset: rst_n clears scan mode, token start, byte position and the result queue at once.
module token_scanner_unit #(
    parameter int POS_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind_code,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic        last_of_run
);
    import tsu_pkg::*;

    // Positions carry one extra bit so that "offset after the last byte" never wraps.
    localparam int W  = POS_BITS + 1;
    localparam int EW = W + 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_IDENT,
        MODE_STAR,
        MODE_MINUS,
        MODE_SLASH,
        MODE_COMMENT
    } mode_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [15:0] sat16(input logic [W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > EW'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic result_t make_res(input logic [3:0] kind,
                                         input logic [W-1:0] s,
                                         input logic [W-1:0] e);
        result_t r;
        r.kind  = kind;
        r.start = sat16(s);
        r.len   = sat16((e >= s) ? (e - s) : '0);
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [3:0] pending_kind(input mode_t m);
        logic [3:0] k;
        unique case (m)
            MODE_INT, MODE_FRAC: k = KIND_NUM;
            MODE_IDENT:          k = KIND_IDENT;
            MODE_STAR:           k = KIND_STAR;
            MODE_MINUS:          k = KIND_MINUS;
            default:             k = KIND_SLASH;
        endcase
        return k;
    endfunction

    mode_t                 mode_reg, mode_next;
    logic [POS_BITS-1:0]   tstart_reg, tstart_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    result_t               q_reg [QDEPTH];
    result_t               q_next [QDEPTH];
    logic [2:0]            cnt_reg, cnt_next;

    logic                  push, pop;
    logic [W-1:0]          p_ext, p1, ts_ext;
    mode_t                 mode_a, mode_b;
    logic [POS_BITS-1:0]   ts_b;
    logic                  to_idle, eof_done;
    result_t               cand [4];
    logic [3:0]            cand_vld;
    result_t               new_items [QDEPTH];
    logic [2:0]            n_new;
    logic [2:0]            last_idx;
    logic [3:0]            b_kind;
    result_t               sh [QDEPTH];
    logic [2:0]            base;
    logic [2:0]            off [QDEPTH];

    assign in_ready = (cnt_reg <= 3'(QDEPTH - MAX_RES));
    assign push     = in_valid && in_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign pop      = out_valid && out_ready;

    assign token_kind_code = q_reg[0].kind;
    assign start_offset    = q_reg[0].start;
    assign token_length    = q_reg[0].len;
    assign last_of_run     = q_reg[0].last;

    assign p_ext    = W'(pos_reg);
    assign p1       = p_ext + W'(1);
    assign ts_ext   = W'(tstart_reg);

    // Scan one byte: close the pending token, handle the byte from idle, then end of input.
    always_comb
    begin
        mode_a   = mode_reg;
        to_idle  = 1'b0;
        cand_vld = '0;
        cand[0]  = make_res(pending_kind(mode_reg), ts_ext, p_ext);
        unique case (mode_reg)
            MODE_IDLE:
            begin
                to_idle = 1'b1;
            end
            MODE_INT:
            begin
                if (is_digit(char_byte))
                begin
                end
                else if (char_byte == CH_DOT)
                begin
                    mode_a = MODE_FRAC;
                end
                else
                begin
                    cand_vld[0] = 1'b1;
                    to_idle     = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (!is_digit(char_byte))
                begin
                    cand_vld[0] = 1'b1;
                    to_idle     = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (!(is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_UNDER))
                begin
                    cand_vld[0] = 1'b1;
                    to_idle     = 1'b1;
                end
            end
            MODE_STAR:
            begin
                cand_vld[0] = 1'b1;
                if (char_byte == CH_STAR)
                begin
                    cand[0] = make_res(KIND_STARSTAR, ts_ext, p1);
                    mode_a  = MODE_IDLE;
                end
                else
                begin
                    to_idle = 1'b1;
                end
            end
            MODE_MINUS, MODE_SLASH:
            begin
                if (char_byte == ((mode_reg == MODE_MINUS) ? CH_MINUS : CH_SLASH))
                begin
                    mode_a = MODE_COMMENT;
                end
                else
                begin
                    cand_vld[0] = 1'b1;
                    to_idle     = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (char_byte == CH_NL)
                begin
                    mode_a = MODE_IDLE;
                end
            end
        endcase

        // Byte seen from idle
        mode_b   = mode_a;
        ts_b     = tstart_reg;
        eof_done = 1'b0;
        b_kind   = KIND_UNKNOWN;
        if (to_idle)
        begin
            mode_b = MODE_IDLE;
            if (char_byte == CH_NUL)
            begin
                cand_vld[1] = 1'b1;
                eof_done    = end_of_input;
                b_kind      = end_of_input ? KIND_EOF : KIND_NULLDIAG;
            end
            else if (!is_space(char_byte))
            begin
                ts_b = pos_reg;
                priority if (is_digit(char_byte))
                    mode_b = MODE_INT;
                else if (is_alpha(char_byte) || char_byte == CH_UNDER)
                    mode_b = MODE_IDENT;
                else if (char_byte == CH_STAR)
                    mode_b = MODE_STAR;
                else if (char_byte == CH_MINUS)
                    mode_b = MODE_MINUS;
                else if (char_byte == CH_SLASH)
                    mode_b = MODE_SLASH;
                else
                begin
                    cand_vld[1] = 1'b1;
                    unique case (char_byte)
                        CH_LPAREN: b_kind = KIND_LPAREN;
                        CH_RPAREN: b_kind = KIND_RPAREN;
                        CH_LBRACE: b_kind = KIND_LBRACE;
                        CH_RBRACE: b_kind = KIND_RBRACE;
                        CH_PLUS:   b_kind = KIND_PLUS;
                        CH_SEMI:   b_kind = KIND_SEMI;
                        CH_COMMA:  b_kind = KIND_COMMA;
                        default:   b_kind = KIND_UNKNOWN;
                    endcase
                end
            end
        end
        cand[1] = make_res(b_kind, p_ext, p1);

        // End of input: flush the pending token including this byte, then eof
        cand[2] = make_res(pending_kind(mode_b), W'(ts_b), p1);
        cand[3] = make_res(KIND_EOF, p1, p1);
        cand_vld[2] = end_of_input && !eof_done &&
                      (mode_b != MODE_IDLE) && (mode_b != MODE_COMMENT);
        cand_vld[3] = end_of_input && !eof_done;

        if (end_of_input)
        begin
            mode_next   = MODE_IDLE;
            tstart_next = '0;
            pos_next    = '0;
        end
        else
        begin
            mode_next   = mode_b;
            tstart_next = ts_b;
            pos_next    = (pos_reg < POS_MAX) ? (pos_reg + POS_BITS'(1)) : POS_MAX;
        end
    end

    // Pack the valid results in order and mark the last one
    always_comb
    begin
        n_new = 3'd0;
        for (int i = 0; i < QDEPTH; i++)
            new_items[i] = cand[0];
        for (int i = 0; i < 4; i++)
        begin
            if (cand_vld[i])
            begin
                new_items[n_new[1:0]] = cand[i];
                n_new = n_new + 3'd1;
            end
        end
        last_idx = n_new - 3'd1;
        if (n_new != 3'd0)
            new_items[last_idx[1:0]].last = 1'b1;
    end

    // Queue: drop the head on a pop, append new beats behind what stays
    always_comb
    begin
        for (int i = 0; i < QDEPTH - 1; i++)
            sh[i] = pop ? q_reg[i+1] : q_reg[i];
        sh[QDEPTH-1] = q_reg[QDEPTH-1];
        base = cnt_reg - {2'b00, pop};
        for (int i = 0; i < QDEPTH; i++)
        begin
            off[i] = 3'(i) - base;
            if (3'(i) < base)
                q_next[i] = sh[i];
            else if (push && (off[i] < n_new))
                q_next[i] = new_items[off[i][1:0]];
            else
                q_next[i] = sh[i];
        end
        cnt_next = base + (push ? n_new : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            tstart_reg <= '0;
            pos_reg    <= '0;
            cnt_reg    <= 3'd0;
            for (int i = 0; i < QDEPTH; i++)
                q_reg[i] <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg   <= mode_next;
                tstart_reg <= tstart_next;
                pos_reg    <= pos_next;
            end
            cnt_reg <= cnt_next;
            for (int i = 0; i < QDEPTH; i++)
                q_reg[i] <= q_next[i];
        end
    end

endmodule

/* rtl/core/tsu_checker.sv */
module tsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  char_byte,
    input logic        end_of_input,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind_code,
    input logic [15:0] start_offset,
    input logic [15:0] token_length,
    input logic        last_of_run
);
    import tsu_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind_code) &&
        $stable(start_offset) && $stable(token_length) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    // Eof always closes the run of its byte
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind_code == KIND_EOF |-> last_of_run)
        else $error("eof beat not marked last");

    // A null diagnostic covers one byte and closes its run
    a_null_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind_code == KIND_NULLDIAG |-> last_of_run && token_length == 16'd1)
        else $error("null diagnostic malformed");

    // Single-byte tokens have length one
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind_code == KIND_LPAREN || token_kind_code == KIND_RPAREN ||
        token_kind_code == KIND_LBRACE || token_kind_code == KIND_RBRACE ||
        token_kind_code == KIND_PLUS || token_kind_code == KIND_SEMI ||
        token_kind_code == KIND_COMMA || token_kind_code == KIND_UNKNOWN)
        |-> token_length == 16'd1)
        else $error("single-byte token with wrong length");

endmodule

bind token_scanner_unit tsu_checker u_tsu_checker (.*);
